// File: rtl/binary_to_decimal_ascii_top_assert.svh
// Assertion macros used by the converter top level.
// Each expects clk and rst_n in scope.
`ifndef BINARY_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define B2DA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("b2da assertion failed");

// Next-cycle implication, checked out of reset.
`define B2DA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("b2da assertion failed");

`endif

// File: rtl/b2da_pkg.sv
`timescale 1ns / 1ps

package b2da_pkg;

  localparam int VALUE_BITS = 64;
  localparam int CHAR_BITS  = 6;
  localparam int DIGIT_BITS = 4;

  localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 6'd48;
  localparam logic [CHAR_BITS-1:0] ASCII_NINE = 6'd57;

  typedef struct packed {
    logic start;
    logic shift_dig;
  } b2da_ctrl_t;

  typedef struct packed {
    logic busy;
  } b2da_status_t;

  // Shift-and-add-3 correction of one BCD digit before the next doubling.
  function automatic logic [DIGIT_BITS-1:0] dabble_adj(input logic [DIGIT_BITS-1:0] d);
    dabble_adj = (d >= 4'd5) ? d + 4'd3 : d;
  endfunction

endpackage

// File: rtl/b2da_if.sv
`timescale 1ns / 1ps

interface b2da_in_if;
  import b2da_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface b2da_out_if;
  import b2da_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] digit_char;
  logic                 last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

// File: rtl/b2da_conv.sv
`timescale 1ns / 1ps

module b2da_conv #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  b2da_pkg::b2da_ctrl_t   ctrl,
  input  logic [VALUE_WIDTH-1:0] value,
  output b2da_pkg::b2da_status_t status,
  output logic [3:0]             top_digit
);
  import b2da_pkg::*;

  localparam int NumDigits = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int BcdBits   = NumDigits * DIGIT_BITS;
  localparam int CntW      = $clog2(VALUE_WIDTH + 1);

  logic [BcdBits-1:0]     bcd_r, bcd_nxt, bcd_adj;
  logic [VALUE_WIDTH-1:0] bin_r, bin_nxt;
  logic [CntW-1:0]        cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;

  // Correct every digit lane in parallel; each lane is independent.
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] = dabble_adj(bcd_r[i*DIGIT_BITS +: DIGIT_BITS]);
    end
  end

  always_comb begin
    bcd_nxt  = bcd_r;
    bin_nxt  = bin_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (ctrl.start) begin
      bcd_nxt  = '0;
      bin_nxt  = value;
      cnt_nxt  = CntW'(VALUE_WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // Shift one binary bit into the BCD chain, MSB first.
      bcd_nxt = {bcd_adj[BcdBits-2:0], bin_r[VALUE_WIDTH-1]};
      bin_nxt = {bin_r[VALUE_WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r - CntW'(1);
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
      end
    end else if (ctrl.shift_dig) begin
      // Advance to the next lower digit.
      bcd_nxt = {bcd_r[BcdBits-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    bcd_r <= bcd_nxt;
    bin_r <= bin_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  assign status.busy = busy_r;
  assign top_digit   = bcd_r[BcdBits-1 -: DIGIT_BITS];

endmodule

// File: rtl/binary_to_decimal_ascii_top.sv
// Flow: the input transaction starts a bit-serial double-dabble conversion, then the
// leading-zero skip, then the digit shift-out, most significant digit first.
// A new number is taken once the previous one's last digit is in the output register.
// Conversion runs one bit per cycle; shift-out one digit per cycle unless out_ch stalls.
// Reset: synchronous active-low rst_n returns the control to idle and drops out valid.
`timescale 1ns / 1ps
`include "binary_to_decimal_ascii_top_assert.svh"

module binary_to_decimal_ascii_top #(
  parameter int VALUE_WIDTH = 64
) (
  input logic        clk,
  input logic        rst_n,
  b2da_in_if.sink    in_ch,
  b2da_out_if.source out_ch
);
  import b2da_pkg::*;

  localparam int NumDigits = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int RemW      = $clog2(NumDigits + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SKIP = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t               st_r, st_nxt;
  logic [RemW-1:0]      remain_r, remain_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CHAR_BITS-1:0] out_char_r, out_char_nxt;
  logic                 out_last_r, out_last_nxt;

  b2da_ctrl_t   ctrl;
  b2da_status_t status;
  logic [3:0]   top_digit;
  logic         in_fire;
  logic         load_digit;

  b2da_conv #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .value     (in_ch.value[VALUE_WIDTH-1:0]),
    .status    (status),
    .top_digit (top_digit)
  );

  assign in_ch.ready = (st_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign load_digit  = (st_r == ST_EMIT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    st_nxt         = st_r;
    remain_nxt     = remain_r;
    ctrl.start     = 1'b0;
    ctrl.shift_dig = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          ctrl.start = 1'b1;
          remain_nxt = RemW'(NumDigits);
          st_nxt     = ST_CONV;
        end
      end
      ST_CONV: begin
        if (!status.busy) begin
          st_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // Drop leading zeros, keep at least one digit.
        if (top_digit == 4'd0 && remain_r > RemW'(1)) begin
          ctrl.shift_dig = 1'b1;
          remain_nxt     = remain_r - RemW'(1);
        end else begin
          st_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load_digit) begin
          ctrl.shift_dig = 1'b1;
          remain_nxt     = remain_r - RemW'(1);
          if (remain_r == RemW'(1)) begin
            st_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register: holds one character while the next number converts.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_digit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = ASCII_ZERO + CHAR_BITS'(top_digit);
      out_last_nxt  = (remain_r == RemW'(1));
    end
  end

  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.digit_char = out_char_r;
  assign out_ch.last_digit = out_last_r;

  `B2DA_ASSERT_NOW(a_char_is_digit, out_valid_r, out_char_r >= ASCII_ZERO && out_char_r <= ASCII_NINE)
  `B2DA_ASSERT_NOW(a_skip_has_digits, st_r == ST_SKIP || st_r == ST_EMIT, remain_r != '0)
  `B2DA_ASSERT_NEXT(a_last_ends_run, load_digit && remain_r == RemW'(1), st_r == ST_IDLE && out_last_r)

endmodule

// File: sim/binary_to_decimal_ascii_top_tb.sv
`timescale 1ns / 1ps

module binary_to_decimal_ascii_top_tb;
  import b2da_pkg::*;

  localparam int VALUE_WIDTH = 64;
  localparam logic [VALUE_BITS-1:0] VALUE_MASK =
    (VALUE_WIDTH >= VALUE_BITS) ? {VALUE_BITS{1'b1}} : ((64'd1 << VALUE_WIDTH) - 64'd1);
  localparam int MAX_CHARS    = 20;
  localparam int RANDOM_ITEMS = 360;
  localparam int DRAIN_CYCLES = VALUE_WIDTH + 40;
  localparam int IDLE_LIMIT   = 4000;

  typedef struct packed {
    logic [CHAR_BITS-1:0] digit_char;
    logic                 last_digit;
  } decimal_char_t;

  class decimal_text_board;
    decimal_char_t pending_chars[$];
    int            fails = 0;

    // Expand an accepted number into its ASCII digits, most significant first.
    function void note_number(logic [VALUE_BITS-1:0] number);
      logic [VALUE_BITS-1:0] rest;
      logic [DIGIT_BITS-1:0] digit_rev[MAX_CHARS];
      decimal_char_t         ch;
      int                    count;
      rest  = number & VALUE_MASK;
      count = 0;
      do begin
        digit_rev[count] = DIGIT_BITS'(rest % 64'd10);
        rest = rest / 64'd10;
        count++;
      end while (rest != 0 && count < MAX_CHARS);
      for (int k = count - 1; k >= 0; k--) begin
        ch.digit_char = ASCII_ZERO + CHAR_BITS'(digit_rev[k]);
        ch.last_digit = (k == 0);
        pending_chars.push_back(ch);
      end
    endfunction

    function void check_char(logic [CHAR_BITS-1:0] digit_char, logic last_digit);
      decimal_char_t want;
      if (pending_chars.size() == 0) begin
        $error("unexpected character: digit_char %0d last_digit %0d", digit_char, last_digit);
        fails++;
        return;
      end
      want = pending_chars.pop_front();
      if (digit_char !== want.digit_char) begin
        $error("digit_char mismatch: expected %0d, actual %0d", want.digit_char, digit_char);
        fails++;
      end
      if (last_digit !== want.last_digit) begin
        $error("last_digit mismatch: expected %0d, actual %0d", want.last_digit, last_digit);
        fails++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  b2da_in_if  in_ch ();
  b2da_out_if out_ch ();

  binary_to_decimal_ascii_top #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  decimal_text_board board = new();

  int burst_left;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [VALUE_BITS-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  task automatic send_number(input logic [VALUE_BITS-1:0] number);
    int gap;
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.value = number;
    do @(posedge clk); while (!in_ch.ready);
    board.note_number(number);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
        in_ch.value = random_word();
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Pick numbers of every length, with weight on power-of-ten boundaries.
  function automatic logic [VALUE_BITS-1:0] random_number();
    logic [VALUE_BITS-1:0] power;
    int                    pick;
    pick = $urandom_range(0, 9);
    if (pick <= 3) return random_word();
    if (pick <= 7) return random_word() >> $urandom_range(1, 63);
    power = 64'd1;
    repeat ($urandom_range(1, 19)) power = power * 64'd10;
    case ($urandom_range(0, 2))
      0:       return power - 64'd1;
      1:       return power;
      default: return power + 64'd1;
    endcase
  endfunction

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.value  = '0;
    burst_left   = $urandom_range(1, 12);
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    send_number(64'd0);
    send_number(64'd1);
    send_number(64'd9);
    send_number(64'd10);
    send_number(64'd99);
    send_number(64'd100);
    send_number(64'd12345);
    send_number(64'd4294967295);
    send_number(64'd4294967296);
    send_number(64'd999999999999999999);
    send_number(64'd1000000000000000000);
    send_number(64'd9999999999999999999);
    send_number(64'd10000000000000000000);
    send_number(64'd10000000000000000001);
    send_number(64'd9223372036854775807);
    send_number(64'd9223372036854775808);
    send_number(64'd18446744073709551614);
    send_number(64'd18446744073709551615);
    send_number(64'h5555_5555_5555_5555);
    send_number(64'hAAAA_AAAA_AAAA_AAAA);
    send_number(64'd0);

    repeat (RANDOM_ITEMS) send_number(random_number());

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (board.pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.fails == 0) begin
      $display("[binary_to_decimal_ascii_top] OK");
    end else begin
      $display("[binary_to_decimal_ascii_top] ERROR");
    end
    $finish;
  end

  // Receiver backpressure: switch among free-flowing, coin-flip, periodic and long stalls.
  initial begin
    int mode;
    int mode_left;
    int stall_left;
    int phase;
    out_ch.ready = 1'b0;
    mode_left    = 0;
    stall_left   = 0;
    phase        = 0;
    mode         = 0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      phase++;
      case (mode)
        0: out_ch.ready = 1'b1;
        1: out_ch.ready = 1'($urandom_range(0, 1));
        2: out_ch.ready = (phase % 4) != 3;
        default: begin
          if (stall_left > 0) begin
            out_ch.ready = 1'b0;
            stall_left--;
          end else begin
            out_ch.ready = 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 16);
          end
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      board.check_char(out_ch.digit_char, out_ch.last_digit);
    end
    // Hang detection: count cycles with no transaction on either channel.
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $error("no transaction for %0d cycles", IDLE_LIMIT);
      $display("[binary_to_decimal_ascii_top] ERROR");
      $finish;
    end
  end

  initial idle_cycles = 0;

endmodule

// File: binary_to_decimal_ascii_top.f
+incdir+rtl
rtl/b2da_pkg.sv
rtl/b2da_if.sv
rtl/b2da_conv.sv
rtl/binary_to_decimal_ascii_top.sv
sim/binary_to_decimal_ascii_top_tb.sv
